// ===== hdl/frlcm_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
package frlcm_pkg;

    localparam int RING_RECORDS        = 32768;
    localparam int RECORD_BYTES        = 64;
    localparam int RECORDS_PER_SECTOR  = 64;
    localparam int JOURNAL_SLOTS       = 256;
    localparam int JOURNAL_ENTRY_BYTES = 16;

    localparam int MODE_W = 2;
    localparam int ARG_W  = 32;
    localparam int CMD_W  = 3;
    localparam int ADDR_W = 24;
    localparam int SEQ_W  = 32;
    localparam int PEND_W = 16;
    localparam int IDX_W  = 1;

    localparam int RING_IDX_W   = $clog2(RING_RECORDS);
    localparam int REC_SHIFT    = $clog2(RECORD_BYTES);
    localparam int SECTOR_BYTES = RECORDS_PER_SECTOR * RECORD_BYTES;
    localparam int SECTOR_SHIFT = $clog2(SECTOR_BYTES);
    localparam int KEEP_RECORDS = (RING_RECORDS > RECORDS_PER_SECTOR) ?
                                  (RING_RECORDS - RECORDS_PER_SECTOR) : 0;
    localparam int JENT_SHIFT   = $clog2(JOURNAL_ENTRY_BYTES);
    localparam int SLOT_W       = $clog2(JOURNAL_SLOTS + 1);

    localparam logic [ADDR_W-1:0] DATA_BASE_RESET = ADDR_W'(4096);

    localparam logic [MODE_W-1:0] MODE_APPEND  = 2'd0;
    localparam logic [MODE_W-1:0] MODE_PEEK    = 2'd1;
    localparam logic [MODE_W-1:0] MODE_ADVANCE = 2'd2;

    localparam logic [CMD_W-1:0] CMD_NONE            = 3'd0;
    localparam logic [CMD_W-1:0] CMD_ERASE_SECTOR    = 3'd1;
    localparam logic [CMD_W-1:0] CMD_PROGRAM_RECORD  = 3'd2;
    localparam logic [CMD_W-1:0] CMD_READ_RECORD     = 3'd3;
    localparam logic [CMD_W-1:0] CMD_ERASE_JOURNAL   = 3'd4;
    localparam logic [CMD_W-1:0] CMD_PROGRAM_JOURNAL = 3'd5;

    localparam logic [IDX_W-1:0] REG_DATA_BASE = 1'd0;
    localparam logic [IDX_W-1:0] REG_FLASH_OK  = 1'd1;

    typedef struct packed {
        logic load;
        logic emit;
        logic second;
    } t_ctrl_cmd;

    typedef struct packed {
        logic need_pre;
        logic out_free;
    } t_dp_status;

    typedef struct packed {
        logic [CMD_W-1:0]  command;
        logic [ADDR_W-1:0] flash_address;
        logic [SEQ_W-1:0]  sequence_res;
        logic [SEQ_W-1:0]  tail_value;
        logic              accepted;
        logic [PEND_W-1:0] pending_count;
        logic              last;
    } t_result;

endpackage
`default_nettype wire

// ===== hdl/frlcm_if.sv =====
`timescale 1ns / 1ps
`default_nettype none
interface frlcm_in_if;
    logic                           valid;
    logic                           ready;
    logic [frlcm_pkg::MODE_W-1:0]   mode;
    logic [frlcm_pkg::ARG_W-1:0]    count_or_index;

    modport source(output valid, output mode, output count_or_index, input ready);
    modport sink(input valid, input mode, input count_or_index, output ready);
endinterface

interface frlcm_out_if;
    logic                           valid;
    logic                           ready;
    logic [frlcm_pkg::CMD_W-1:0]    command;
    logic [frlcm_pkg::ADDR_W-1:0]   flash_address;
    logic [frlcm_pkg::SEQ_W-1:0]    sequence_res;
    logic [frlcm_pkg::SEQ_W-1:0]    tail_value;
    logic                           accepted;
    logic [frlcm_pkg::PEND_W-1:0]   pending_count;
    logic                           last;

    modport source(output valid, output command, output flash_address,
                   output sequence_res, output tail_value, output accepted,
                   output pending_count, output last, input ready);
    modport sink(input valid, input command, input flash_address,
                 input sequence_res, input tail_value, input accepted,
                 input pending_count, input last, output ready);
endinterface
`default_nettype wire

// ===== hdl/frlcm_ctrl.sv =====
`timescale 1ns / 1ps
`default_nettype none
module frlcm_ctrl (
    input  wire                    i_clk,
    input  wire                    i_rst_n,
    input  wire                    i_in_valid,
    output logic                   o_in_ready,
    input  wire frlcm_pkg::t_dp_status i_status,
    output frlcm_pkg::t_ctrl_cmd   o_cmd
);

    localparam logic [1:0] S_IDLE   = 2'd0;
    localparam logic [1:0] S_FIRST  = 2'd1;
    localparam logic [1:0] S_SECOND = 2'd2;

    logic [1:0] r_state;
    logic [1:0] n_state;

    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_in_ready = 1'b0;
        case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_FIRST;
                end
            end
            S_FIRST: begin
                if (i_status.out_free) begin
                    o_cmd.emit = 1'b1;
                    n_state    = i_status.need_pre ? S_SECOND : S_IDLE;
                end
            end
            S_SECOND: begin
                if (i_status.out_free) begin
                    o_cmd.emit   = 1'b1;
                    o_cmd.second = 1'b1;
                    n_state      = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule
`default_nettype wire

// ===== hdl/frlcm_dpath.sv =====
`timescale 1ns / 1ps
`default_nettype none
module frlcm_dpath (
    input  wire                                i_clk,
    input  wire                                i_rst_n,
    input  wire                                i_cfg_we,
    input  wire  [frlcm_pkg::IDX_W-1:0]        i_cfg_index,
    input  wire  [frlcm_pkg::ADDR_W-1:0]       i_cfg_data,
    input  wire  [frlcm_pkg::MODE_W-1:0]       i_mode,
    input  wire  [frlcm_pkg::ARG_W-1:0]        i_arg,
    input  wire  frlcm_pkg::t_ctrl_cmd         i_cmd,
    output frlcm_pkg::t_dp_status              o_status,
    input  wire                                i_out_ready,
    output logic                               o_out_valid,
    output frlcm_pkg::t_result                 o_result
);

    logic [frlcm_pkg::ADDR_W-1:0] r_data_base;
    logic                         r_flash_ok;
    logic [frlcm_pkg::SEQ_W-1:0]  r_head;
    logic [frlcm_pkg::SEQ_W-1:0]  r_tail;
    logic [frlcm_pkg::SLOT_W-1:0] r_slot;
    logic [frlcm_pkg::MODE_W-1:0] r_mode;
    logic [frlcm_pkg::ARG_W-1:0]  r_arg;
    logic                         r_out_valid;
    frlcm_pkg::t_result           r_out;

    logic [frlcm_pkg::SEQ_W-1:0]  n_head;
    logic [frlcm_pkg::SEQ_W-1:0]  n_tail;
    logic [frlcm_pkg::SLOT_W-1:0] n_slot;
    frlcm_pkg::t_result           n_out;

    logic [frlcm_pkg::SEQ_W-1:0]  w_pending;
    logic [frlcm_pkg::SEQ_W-1:0]  w_adv;
    logic [frlcm_pkg::SEQ_W-1:0]  w_adv_tail;
    logic [frlcm_pkg::SEQ_W-1:0]  w_trim_tail;
    logic [frlcm_pkg::SEQ_W-1:0]  w_peek_seq;
    logic [frlcm_pkg::ADDR_W-1:0] w_head_addr;
    logic [frlcm_pkg::ADDR_W-1:0] w_peek_addr;
    logic [frlcm_pkg::ADDR_W-1:0] w_jaddr;
    logic                         w_sector_start;
    logic                         w_slot_full;
    logic                         w_need_pre;
    logic                         w_pre;
    logic                         w_out_free;

    function automatic logic [frlcm_pkg::ADDR_W-1:0] rec_addr(
        input logic [frlcm_pkg::ADDR_W-1:0] base,
        input logic [frlcm_pkg::SEQ_W-1:0]  seq
    );
        logic [frlcm_pkg::ADDR_W-1:0] off;
        off = frlcm_pkg::ADDR_W'(seq[frlcm_pkg::RING_IDX_W-1:0]) << frlcm_pkg::REC_SHIFT;
        return base + off;
    endfunction

    assign w_pending      = r_head - r_tail;
    assign w_adv          = (r_arg < w_pending) ? r_arg : w_pending;
    assign w_adv_tail     = r_tail + w_adv;
    assign w_trim_tail    = (w_pending > frlcm_pkg::SEQ_W'(frlcm_pkg::KEEP_RECORDS)) ?
                            (r_head - frlcm_pkg::SEQ_W'(frlcm_pkg::KEEP_RECORDS)) : r_tail;
    assign w_peek_seq     = r_tail + r_arg;
    assign w_head_addr    = rec_addr(r_data_base, r_head);
    assign w_peek_addr    = rec_addr(r_data_base, w_peek_seq);
    assign w_jaddr        = frlcm_pkg::ADDR_W'(r_slot) << frlcm_pkg::JENT_SHIFT;
    assign w_sector_start = (w_head_addr[frlcm_pkg::SECTOR_SHIFT-1:0] == '0);
    assign w_slot_full    = (r_slot >= frlcm_pkg::SLOT_W'(frlcm_pkg::JOURNAL_SLOTS));
    assign w_need_pre     = ((r_mode == frlcm_pkg::MODE_APPEND) && r_flash_ok && w_sector_start)
                          || ((r_mode == frlcm_pkg::MODE_ADVANCE) && w_slot_full);
    assign w_pre          = w_need_pre && !i_cmd.second;
    assign w_out_free     = !r_out_valid || i_out_ready;

    assign o_status.need_pre = w_need_pre;
    assign o_status.out_free = w_out_free;
    assign o_out_valid       = r_out_valid;
    assign o_result          = r_out;

    always_comb begin
        n_head = r_head;
        n_tail = r_tail;
        n_slot = r_slot;
        n_out  = '0;
        n_out.command = frlcm_pkg::CMD_NONE;
        n_out.last    = 1'b1;
        case (r_mode)
            frlcm_pkg::MODE_APPEND: begin
                if (r_flash_ok) begin
                    n_out.accepted      = 1'b1;
                    n_out.flash_address = w_head_addr;
                    n_out.sequence_res  = r_head;
                    if (w_pre) begin
                        n_tail        = w_trim_tail;
                        n_out.command = frlcm_pkg::CMD_ERASE_SECTOR;
                        n_out.last    = 1'b0;
                    end else begin
                        n_head        = r_head + 1'b1;
                        n_out.command = frlcm_pkg::CMD_PROGRAM_RECORD;
                    end
                end
            end
            frlcm_pkg::MODE_PEEK: begin
                if (r_flash_ok && (r_arg < w_pending)) begin
                    n_out.accepted      = 1'b1;
                    n_out.command       = frlcm_pkg::CMD_READ_RECORD;
                    n_out.flash_address = w_peek_addr;
                    n_out.sequence_res  = w_peek_seq;
                end
            end
            frlcm_pkg::MODE_ADVANCE: begin
                n_out.accepted     = 1'b1;
                n_out.sequence_res = r_head;
                if (!i_cmd.second) begin
                    n_tail = w_adv_tail;
                end
                if (w_pre) begin
                    n_slot        = '0;
                    n_out.command = frlcm_pkg::CMD_ERASE_JOURNAL;
                    n_out.last    = 1'b0;
                end else begin
                    n_slot              = r_slot + 1'b1;
                    n_out.command       = frlcm_pkg::CMD_PROGRAM_JOURNAL;
                    n_out.flash_address = w_jaddr;
                end
            end
            default: begin
                n_out.command = frlcm_pkg::CMD_NONE;
            end
        endcase
        n_out.tail_value    = n_tail;
        n_out.pending_count = frlcm_pkg::PEND_W'(n_head - n_tail);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_data_base <= frlcm_pkg::DATA_BASE_RESET;
            r_flash_ok  <= 1'b0;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                frlcm_pkg::REG_DATA_BASE: r_data_base <= i_cfg_data;
                frlcm_pkg::REG_FLASH_OK:  r_flash_ok  <= i_cfg_data[0];
                default: begin
                    r_flash_ok <= r_flash_ok;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head      <= '0;
            r_tail      <= '0;
            r_slot      <= '0;
            r_out_valid <= 1'b0;
        end else if (i_cmd.emit) begin
            r_head      <= n_head;
            r_tail      <= n_tail;
            r_slot      <= n_slot;
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_mode <= i_mode;
            r_arg  <= i_arg;
        end
        if (i_cmd.emit) begin
            r_out <= n_out;
        end
    end

endmodule
`default_nettype wire

// ===== hdl/flash_ring_log_cursor_manager_unit.sv =====
`timescale 1ns / 1ps
`default_nettype none
// Flash ring log cursor manager.
// Input channel i_in carries one request word: mode (append, peek, advance)
// and count_or_index. Output channel o_out carries flash command words; each
// request yields one or two words, the final one flagged by last. An append
// at a sector start yields an erase sector word before the program word; an
// advance with a full journal yields an erase journal word before the
// journal program word. Rejected requests yield one word with command none.
// Configuration: i_cfg_we writes i_cfg_data to register i_cfg_index
// (0 data_base, 1 flash_ok) at the clock edge; write only while idle.
// Timing: a request is taken in the idle state, and each result word is
// loaded into the output register from the first and then the second
// state; the controller handles one request at a time. The output
// register holds a word until o_out.ready; while it stalls the controller
// waits, and a new request is still taken once the previous one has
// issued all its words.
// Reset (synchronous, active low): head, tail and journal slot clear,
// data_base returns to 4096, flash_ok to 0, output goes empty.
module flash_ring_log_cursor_manager_unit (
    input  wire                          i_clk,
    input  wire                          i_rst_n,
    frlcm_in_if.sink                     i_in,
    frlcm_out_if.source                  o_out,
    input  wire                          i_cfg_we,
    input  wire  [frlcm_pkg::IDX_W-1:0]  i_cfg_index,
    input  wire  [frlcm_pkg::ADDR_W-1:0] i_cfg_data
);

    frlcm_pkg::t_ctrl_cmd  w_cmd;
    frlcm_pkg::t_dp_status w_status;
    frlcm_pkg::t_result    w_result;
    logic                  w_in_ready;
    logic                  w_out_valid;

    frlcm_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in.valid),
        .o_in_ready (w_in_ready),
        .i_status   (w_status),
        .o_cmd      (w_cmd)
    );

    frlcm_dpath u_dpath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_mode      (i_in.mode),
        .i_arg       (i_in.count_or_index),
        .i_cmd       (w_cmd),
        .o_status    (w_status),
        .i_out_ready (o_out.ready),
        .o_out_valid (w_out_valid),
        .o_result    (w_result)
    );

    assign i_in.ready          = w_in_ready;
    assign o_out.valid         = w_out_valid;
    assign o_out.command       = w_result.command;
    assign o_out.flash_address = w_result.flash_address;
    assign o_out.sequence_res  = w_result.sequence_res;
    assign o_out.tail_value    = w_result.tail_value;
    assign o_out.accepted      = w_result.accepted;
    assign o_out.pending_count = w_result.pending_count;
    assign o_out.last          = w_result.last;

endmodule
`default_nettype wire

// ===== hdl/frlcm_chk.sv =====
`timescale 1ns / 1ps
`default_nettype none
module frlcm_chk (
    input wire                          i_clk,
    input wire                          i_rst_n,
    input wire                          i_in_valid,
    input wire                          i_in_ready,
    input wire                          i_out_valid,
    input wire                          i_out_ready,
    input wire [frlcm_pkg::CMD_W-1:0]   i_command,
    input wire [frlcm_pkg::ADDR_W-1:0]  i_address,
    input wire [frlcm_pkg::SEQ_W-1:0]   i_sequence,
    input wire                          i_accepted,
    input wire                          i_last
);

    a_busy_after_take: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && i_in_ready) |=> !i_in_ready)
        else $error("request taken while previous one still in work");

    a_reject_shape: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && (i_command == frlcm_pkg::CMD_NONE)) |->
        (!i_accepted && i_last && (i_address == '0) && (i_sequence == '0)))
        else $error("rejected word carries payload");

    a_pre_word_is_erase: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && !i_last) |->
        ((i_command == frlcm_pkg::CMD_ERASE_SECTOR) ||
         (i_command == frlcm_pkg::CMD_ERASE_JOURNAL)))
        else $error("non-final word is not an erase");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && !i_out_ready) |=> (i_out_valid && $stable(i_command)))
        else $error("stalled output word dropped or changed");

endmodule

bind flash_ring_log_cursor_manager_unit frlcm_chk u_frlcm_chk (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in.valid),
    .i_in_ready  (i_in.ready),
    .i_out_valid (o_out.valid),
    .i_out_ready (o_out.ready),
    .i_command   (o_out.command),
    .i_address   (o_out.flash_address),
    .i_sequence  (o_out.sequence_res),
    .i_accepted  (o_out.accepted),
    .i_last      (o_out.last)
);
`default_nettype wire
